// ===== rtl/core/mve_pkg.sv =====
// Shared types, constants and elaboration-time tables for the synth voice.
package mve_pkg;

    // Audio format and oscillator geometry.
    localparam int SINE_DEPTH     = 1024;
    localparam int SAMPLE_BITS    = 16;
    localparam int SAMPLE_RATE_HZ = 48000;

    localparam int IDX_W   = $clog2(SINE_DEPTH);
    localparam int QTR_W   = IDX_W - 2;
    localparam int QUARTER = SINE_DEPTH / 4;
    localparam int AMP_W   = SAMPLE_BITS - 1;

    // Configuration port geometry.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Shared multiply-add unit geometry.
    localparam int MAC_IN_W  = 24;
    localparam int MAC_ADD_W = 23;
    localparam int MAC_W     = 2 * MAC_IN_W;

    localparam longint unsigned Q30_ONE     = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Sample rate and its half, as 64-bit constants for the note table.
    localparam longint unsigned RATE_L      = SAMPLE_RATE_HZ;
    localparam longint unsigned RATE_HALF_L = SAMPLE_RATE_HZ / 2;

    typedef struct packed {
        logic [15:0] gain;
        logic [30:0] free_phase_step;
        logic [23:0] attack_step;
        logic [23:0] decay_step;
    } cfg_t;

    typedef struct packed {
        logic                 en;
        logic [MAC_IN_W-1:0]  a;
        logic [MAC_IN_W-1:0]  b;
        logic [MAC_ADD_W-1:0] c;
    } mac_op_t;

    typedef logic [AMP_W-1:0] sine_rom_t [QUARTER];
    typedef logic [31:0]      note_rom_t [128];

    // Lowest octave of the equal-tempered scale in Q16 Hz.
    function automatic longint unsigned octave_base(input int unsigned i);
        longint unsigned f;
        case (i)
            0:       f = 64'd535809;
            1:       f = 64'd567670;
            2:       f = 64'd601425;
            3:       f = 64'd637188;
            4:       f = 64'd675077;
            5:       f = 64'd715219;
            6:       f = 64'd757749;
            7:       f = 64'd802807;
            8:       f = 64'd850544;
            9:       f = 64'd901120;
            10:      f = 64'd954703;
            default: f = 64'd1011473;
        endcase
        return f;
    endfunction

    // Rounded phase increment of semitone k in octave oct, kept modulo 2^32.
    function automatic logic [31:0] note_step(input int unsigned k, input int unsigned oct);
        longint unsigned f;
        longint unsigned num;
        f   = octave_base(k);
        num = (f << (16 + oct)) + RATE_HALF_L;
        return 32'(num / RATE_L);
    endfunction

    function automatic note_rom_t build_note_rom();
        note_rom_t rom;
        for (int oct = 0; oct < 11; oct++) begin
            for (int k = 0; k < 12; k++) begin
                if (oct * 12 + k < 128) begin
                    rom[oct * 12 + k] = note_step(k, oct);
                end
            end
        end
        return rom;
    endfunction

    // Quarter-wave magnitude at fold position j, Q30 Taylor series to x^9.
    function automatic logic [AMP_W-1:0] sine_mag(input int unsigned j);
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned m;
        longint unsigned amp;
        amp = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
        r   = longint'(j) * 64'd4;
        x   = (r * HALF_PI_Q30) >> IDX_W;
        x2  = (x * x) >> 30;
        t   = Q30_ONE - x2 / 64'd72;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        s   = (x * t) >> 30;
        m   = (s * amp + (64'd1 << 29)) >> 30;
        if (m > amp) begin
            m = amp;
        end
        return m[AMP_W-1:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < QUARTER; i++) begin
            rom[i] = sine_mag(i);
        end
        return rom;
    endfunction

    localparam note_rom_t        NOTE_ROM  = build_note_rom();
    localparam sine_rom_t        SINE_ROM  = build_sine_rom();
    localparam logic [AMP_W-1:0] SINE_PEAK = sine_mag(QUARTER);

endpackage

// ===== rtl/core/mve_regs.sv =====
// Configuration register file behind the APB-style port.
module mve_regs
    import mve_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    localparam logic [1:0] REG_GAIN      = 2'd0;
    localparam logic [1:0] REG_FREE_STEP = 2'd1;
    localparam logic [1:0] REG_ATTACK    = 2'd2;
    localparam logic [1:0] REG_DECAY     = 2'd3;

    logic [15:0] gain_reg;
    logic [30:0] free_step_reg;
    logic [23:0] attack_reg;
    logic [23:0] decay_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= 16'd32768;
            free_step_reg <= 31'd39370534;
            attack_reg    <= 24'd17476;
            decay_reg     <= 24'd874;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_GAIN:      gain_reg      <= pwdata[15:0];
                REG_FREE_STEP: free_step_reg <= pwdata[30:0];
                REG_ATTACK:    attack_reg    <= pwdata[23:0];
                REG_DECAY:     decay_reg     <= pwdata[23:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN:      prdata = {16'd0, gain_reg};
            REG_FREE_STEP: prdata = {1'b0, free_step_reg};
            REG_ATTACK:    prdata = {8'd0, attack_reg};
            REG_DECAY:     prdata = {8'd0, decay_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.gain            = gain_reg;
    assign cfg.free_phase_step = free_step_reg;
    assign cfg.attack_step     = attack_reg;
    assign cfg.decay_step      = decay_reg;

endmodule

// ===== rtl/core/mve_mac.sv =====
// Shared multiply-add unit with a registered product.
module mve_mac
    import mve_pkg::*;
(
    input  logic             clk,
    input  mac_op_t          op,
    output logic [MAC_W-1:0] p
);

    logic [MAC_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (op.en)
        begin
            p_reg <= MAC_W'(op.a) * MAC_W'(op.b) + MAC_W'(op.c);
        end
    end

    assign p = p_reg;

endmodule

// ===== rtl/core/mono_synth_voice_envelope_unit.sv =====
// Top level of the monophonic synth voice: note state, envelope, sine and output scaling.
//
//  Channel   Direction  Handshake                    Beat contents
//  --------  ---------  ---------------------------  ---------------------------------------
//  config    in         psel/penable/pwrite, pready  gain, free_phase_step, attack, decay
//  in        in         in_valid / in_stall          op, note, velocity, in_sample, in_present
//  out       out        out_valid / out_stall        out_sample (one beat per tick only)
//
// A note on, note off or unused op beat is absorbed in the cycle it is accepted.
// A tick beat runs through OSC, MUL1, VEL, REC, CORR, GAIN and FIN in synth mode and
// through OSC, MUL1 and FIN in pass-through or free-oscillator mode; the single shared
// multiply-add unit sets this: each scaling step waits for the prior registered product.
// The input is stalled while a tick is in the sequencer. A finished sample sits in
// the output register, so the next beat can be accepted while downstream stalls.
// Reset is asynchronous and active low and returns the voice and registers to idle.
module mono_synth_voice_envelope_unit
    import mve_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         op,
    input  logic [6:0]         note,
    input  logic [6:0]         velocity,
    input  logic signed [15:0] in_sample,
    input  logic               in_present,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_sample
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_OSC  = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_VEL  = 3'd3;
    localparam logic [2:0] S_REC  = 3'd4;
    localparam logic [2:0] S_CORR = 3'd5;
    localparam logic [2:0] S_GAIN = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    // Input operation codes.
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ON   = 2'd1;
    localparam logic [1:0] OP_OFF  = 2'd2;

    // Envelope stages.
    localparam logic [1:0] STG_HOLD   = 2'd0;
    localparam logic [1:0] STG_ATTACK = 2'd1;
    localparam logic [1:0] STG_DECAY  = 2'd2;

    localparam logic [23:0] ENV_ONE = 24'h800000;

    // Fixed-point scaling constants.
    localparam int ENV_SHIFT   = 23;
    localparam int OUT_SHIFT   = SAMPLE_BITS - 1;
    localparam int Y_W         = 22;
    localparam int Q_W         = 16;
    localparam int RECIP_SHIFT = 29;
    localparam int M_W         = MAC_W - OUT_SHIFT;

    localparam logic [MAC_ADD_W-1:0] ENV_HALF  = MAC_ADD_W'(1 << (ENV_SHIFT - 1));
    localparam logic [MAC_ADD_W-1:0] OUT_HALF  = MAC_ADD_W'(1 << (OUT_SHIFT - 1));
    localparam logic [MAC_ADD_W-1:0] VEL_BIAS  = MAC_ADD_W'(63);
    localparam logic [MAC_IN_W-1:0]  RECIP_127 = MAC_IN_W'(4227330);
    localparam logic [Y_W:0]         DIV_127   = (Y_W + 1)'(127);
    localparam logic [M_W-1:0]       NEG_LIMIT = M_W'(32768);
    localparam logic [M_W-1:0]       POS_LIMIT = M_W'(32767);

    cfg_t             cfg;
    mac_op_t          mac_op;
    logic [MAC_W-1:0] mac_p;

    // Control and voice state.
    logic [2:0]  state_reg,      state_next;
    logic        out_valid_reg,  out_valid_next;
    logic [31:0] phase_acc_reg,  phase_acc_next;
    logic [23:0] env_level_reg,  env_level_next;
    logic [1:0]  env_stage_reg,  env_stage_next;
    logic        note_active_reg, note_active_next;
    logic [6:0]  held_note_reg,  held_note_next;
    logic [6:0]  held_vel_reg,   held_vel_next;
    logic [31:0] note_step_reg,  note_step_next;

    // Per-tick working registers.
    logic [IDX_W-1:0] idx_reg,      idx_next;
    logic [15:0]      sample_reg,   sample_next;
    logic             present_reg,  present_next;
    logic [AMP_W-1:0] osc_mag_reg,  osc_mag_next;
    logic             osc_neg_reg,  osc_neg_next;
    logic             synth_reg,    synth_next;
    logic             neg_reg,      neg_next;
    logic [Y_W-1:0]   y_reg,        y_next;
    logic [Q_W-1:0]   q_reg,        q_next;
    logic [15:0]      out_smp_reg,  out_smp_next;

    // Combinational helpers.
    logic [24:0]      env_sum;
    logic [1:0]       quad;
    logic [QTR_W-1:0] fold_k;
    logic [QTR_W-1:0] fold_j;
    logic [16:0]      smp_mag;
    logic [Q_W-1:0]   q0;
    logic [Y_W:0]     q0_x127;
    logic [Y_W:0]     rem;
    logic [M_W-1:0]   m_mag;

    mve_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mve_mac u_mac (
        .clk (clk),
        .op  (mac_op),
        .p   (mac_p)
    );

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_sample = out_smp_reg;

    // The quarter-wave fold: odd quadrants mirror the position, the
    // mirrored zero position lands on the peak just past the table end.
    assign quad    = idx_reg[IDX_W-1 -: 2];
    assign fold_k  = idx_reg[QTR_W-1:0];
    assign fold_j  = quad[0] ? (QTR_W'(0) - fold_k) : fold_k;

    // Magnitude of the incoming sample, where the most negative code gives 32768.
    assign smp_mag = sample_reg[15] ? (17'h10000 - {1'b0, sample_reg}) : {1'b0, sample_reg};

    assign env_sum = {1'b0, env_level_reg} + {1'b0, cfg.attack_step};

    // Division by 127 by reciprocal: the estimate is exact or one short.
    assign q0      = mac_p[RECIP_SHIFT +: Q_W];
    assign q0_x127 = {q0, 7'd0} - {7'd0, q0};
    assign rem     = {1'b0, y_reg} - q0_x127;

    assign m_mag   = mac_p[OUT_SHIFT +: M_W];

    always_comb
    begin
        state_next       = state_reg;
        out_valid_next   = out_valid_reg & out_stall;
        phase_acc_next   = phase_acc_reg;
        env_level_next   = env_level_reg;
        env_stage_next   = env_stage_reg;
        note_active_next = note_active_reg;
        held_note_next   = held_note_reg;
        held_vel_next    = held_vel_reg;
        note_step_next   = note_step_reg;
        idx_next         = idx_reg;
        sample_next      = sample_reg;
        present_next     = present_reg;
        osc_mag_next     = osc_mag_reg;
        osc_neg_next     = osc_neg_reg;
        synth_next       = synth_reg;
        neg_next         = neg_reg;
        y_next           = y_reg;
        q_next           = q_reg;
        out_smp_next     = out_smp_reg;
        mac_op           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (op)
                        OP_TICK:
                        begin
                            // Step the envelope before the oscillator is read.
                            unique case (env_stage_reg)
                                STG_ATTACK:
                                begin
                                    if (env_sum >= {1'b0, ENV_ONE})
                                    begin
                                        env_level_next = ENV_ONE;
                                        env_stage_next = STG_HOLD;
                                    end
                                    else
                                    begin
                                        env_level_next = env_sum[23:0];
                                    end
                                end
                                STG_DECAY:
                                begin
                                    if (cfg.decay_step >= env_level_reg)
                                    begin
                                        env_level_next   = '0;
                                        env_stage_next   = STG_HOLD;
                                        note_active_next = 1'b0;
                                    end
                                    else
                                    begin
                                        env_level_next = env_level_reg - cfg.decay_step;
                                    end
                                end
                                default: ;
                            endcase
                            idx_next     = phase_acc_reg[31 -: IDX_W];
                            sample_next  = in_sample;
                            present_next = in_present;
                            state_next   = S_OSC;
                        end
                        OP_ON, OP_OFF:
                        begin
                            if (op == OP_ON && velocity != 7'd0)
                            begin
                                held_note_next   = note;
                                held_vel_next    = velocity;
                                note_active_next = 1'b1;
                                note_step_next   = NOTE_ROM[note];
                                env_stage_next   = STG_ATTACK;
                            end
                            else if (note_active_reg && note == held_note_reg)
                            begin
                                env_stage_next = STG_DECAY;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_OSC:
            begin
                osc_mag_next = (quad[0] && fold_k == '0) ? SINE_PEAK : SINE_ROM[fold_j];
                osc_neg_next = quad[1];
                synth_next   = note_active_reg || (env_level_reg != '0);
                if (note_active_reg)
                begin
                    phase_acc_next = phase_acc_reg + note_step_reg;
                end
                else
                begin
                    phase_acc_next = phase_acc_reg + {1'b0, cfg.free_phase_step};
                end
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                mac_op.en = 1'b1;
                if (synth_reg)
                begin
                    mac_op.a   = MAC_IN_W'(osc_mag_reg);
                    mac_op.b   = env_level_reg;
                    mac_op.c   = ENV_HALF;
                    neg_next   = osc_neg_reg;
                    state_next = S_VEL;
                end
                else if (present_reg)
                begin
                    mac_op.a   = MAC_IN_W'(smp_mag);
                    mac_op.b   = MAC_IN_W'(cfg.gain);
                    mac_op.c   = OUT_HALF;
                    neg_next   = sample_reg[15];
                    state_next = S_FIN;
                end
                else
                begin
                    mac_op.a   = MAC_IN_W'(osc_mag_reg);
                    mac_op.b   = MAC_IN_W'(cfg.gain);
                    mac_op.c   = OUT_HALF;
                    neg_next   = osc_neg_reg;
                    state_next = S_FIN;
                end
            end
            S_VEL:
            begin
                // Rounded envelope product times velocity, biased for the divide.
                mac_op.en  = 1'b1;
                mac_op.a   = MAC_IN_W'(mac_p[ENV_SHIFT +: AMP_W]);
                mac_op.b   = MAC_IN_W'(held_vel_reg);
                mac_op.c   = VEL_BIAS;
                state_next = S_REC;
            end
            S_REC:
            begin
                mac_op.en  = 1'b1;
                mac_op.a   = MAC_IN_W'(mac_p[Y_W-1:0]);
                mac_op.b   = RECIP_127;
                y_next     = mac_p[Y_W-1:0];
                state_next = S_CORR;
            end
            S_CORR:
            begin
                q_next     = (rem >= DIV_127) ? (q0 + Q_W'(1)) : q0;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                mac_op.en  = 1'b1;
                mac_op.a   = MAC_IN_W'(q_reg);
                mac_op.b   = MAC_IN_W'(cfg.gain);
                mac_op.c   = OUT_HALF;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Wait here only while an earlier sample is still held downstream.
                if (!out_valid_reg || !out_stall)
                begin
                    if (neg_reg)
                    begin
                        out_smp_next = (m_mag > NEG_LIMIT) ? 16'h8000
                                                           : 16'(M_W'(0) - m_mag);
                    end
                    else
                    begin
                        out_smp_next = (m_mag > POS_LIMIT) ? 16'h7FFF : m_mag[15:0];
                    end
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            phase_acc_reg   <= '0;
            env_level_reg   <= '0;
            env_stage_reg   <= STG_HOLD;
            note_active_reg <= 1'b0;
            held_note_reg   <= '0;
            held_vel_reg    <= '0;
            note_step_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            out_valid_reg   <= out_valid_next;
            phase_acc_reg   <= phase_acc_next;
            env_level_reg   <= env_level_next;
            env_stage_reg   <= env_stage_next;
            note_active_reg <= note_active_next;
            held_note_reg   <= held_note_next;
            held_vel_reg    <= held_vel_next;
            note_step_reg   <= note_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        sample_reg  <= sample_next;
        present_reg <= present_next;
        osc_mag_reg <= osc_mag_next;
        osc_neg_reg <= osc_neg_next;
        synth_reg   <= synth_next;
        neg_reg     <= neg_next;
        y_reg       <= y_next;
        q_reg       <= q_next;
        out_smp_reg <= out_smp_next;
    end

endmodule

// ===== dv/mono_synth_voice_envelope_unit_tb.sv =====
// Self-checking testbench for the synth voice: queued note and tick beats checked against a voice predictor.
module mono_synth_voice_envelope_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mve_pkg::*;

    // The run ends here even if the block hangs.
    localparam int unsigned CYCLE_LIMIT     = 400000;
    // Cycles allowed for a tick to leave the sequencer before registers are touched.
    localparam int unsigned SETTLE_CYCLES   = 16;
    // Length of the one long downstream hold-off that backs the voice up.
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned PHASE_BEATS     = 345;
    localparam logic [31:0] ENV_FULL        = 32'd8388608;

    typedef enum logic [1:0] {OP_TICK, OP_NOTE_ON, OP_NOTE_OFF, OP_UNUSED} op_e;
    typedef enum logic [1:0] {STG_HOLD, STG_ATTACK, STG_DECAY} stage_e;
    typedef enum int unsigned {REG_GAIN, REG_FREE_STEP, REG_ATTACK, REG_DECAY} reg_e;

    // One input beat as the sender offers it.
    typedef struct packed {
        op_e         op;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [15:0] smp;
        logic        pres;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] out_sample;

    // The payload ports are taken straight from the beat the driver currently holds.
    beat_t              cur_beat = '0;
    logic [1:0]         op;
    logic [6:0]         note;
    logic [6:0]         velocity;
    logic signed [15:0] in_sample;
    logic               in_present;

    assign op         = cur_beat.op;
    assign note       = cur_beat.note;
    assign velocity   = cur_beat.vel;
    assign in_sample  = cur_beat.smp;
    assign in_present = cur_beat.pres;

    mono_synth_voice_envelope_unit u_top (.*);

    // Predictor copy of the registers.
    logic [15:0] c_gain;
    logic [30:0] c_free_inc;
    logic [23:0] c_attack;
    logic [23:0] c_decay;

    // Predictor copy of the voice state.
    logic [31:0] v_phase;
    logic [31:0] v_env;
    stage_e      v_stage;
    logic        v_note_on;
    logic [6:0]  v_note;
    logic [6:0]  v_vel;
    logic [31:0] v_note_inc;

    beat_t              beat_queue [$];
    logic signed [15:0] predicted_samples [$];

    int unsigned beats_queued = 0;
    int unsigned beats_live = 0;
    int unsigned beats_taken = 0;
    int unsigned n_ticks = 0;
    int unsigned n_note_events = 0;
    int unsigned n_ignored = 0;
    int unsigned n_checked = 0;
    int unsigned n_errors = 0;
    int unsigned n_settings = 0;
    int unsigned cycle_count = 0;

    // Idle rates in percent, changed between phases by the main sequence.
    int unsigned send_idle_pct = 10;
    int unsigned stall_pct = 87;
    logic        hold_arm = 1'b0;
    logic        hold_used = 1'b0;
    int unsigned hold_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void voice_reset();
        c_gain     = 16'd32768;
        c_free_inc = 31'd39370534;
        c_attack   = 24'd17476;
        c_decay    = 24'd874;
        v_phase    = '0;
        v_env      = '0;
        v_stage    = STG_HOLD;
        v_note_on  = 1'b0;
        v_note     = '0;
        v_vel      = '0;
        v_note_inc = '0;
    endfunction

    // Phase increment of a note: the lowest-octave frequency in Q16 Hz, shifted up by the
    // octave, turned into a fraction of the sample rate and rounded.
    function automatic logic [31:0] note_increment(input logic [6:0] n);
        longint unsigned base;
        longint unsigned num;
        case (n % 12)
            0:       base = 535809;
            1:       base = 567670;
            2:       base = 601425;
            3:       base = 637188;
            4:       base = 675077;
            5:       base = 715219;
            6:       base = 757749;
            7:       base = 802807;
            8:       base = 802807 + 47737;
            9:       base = 901120;
            10:      base = 954703;
            default: base = 1011473;
        endcase
        num = (base << (16 + n / 12)) + SAMPLE_RATE_HZ / 2;
        return 32'(num / SAMPLE_RATE_HZ);
    endfunction

    // Signed oscillator value at a phase: the table index is folded to a quarter wave and the
    // sine is computed in Q30 by a truncated Horner evaluation of its series up to x^9.
    function automatic longint osc_value(input logic [31:0] ph);
        longint unsigned depth;
        longint unsigned idx;
        longint unsigned q4;
        longint unsigned quad;
        longint unsigned r;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned m;
        longint unsigned amp;
        depth = SINE_DEPTH;
        idx   = ({32'd0, ph} * depth) >> 32;
        q4    = idx * 4;
        quad  = q4 / depth;
        r     = q4 % depth;
        if (quad[0])
        begin
            r = depth - r;
        end
        x   = r * HALF_PI_Q30 / depth;
        x2  = (x * x) >> 30;
        t   = Q30_ONE - x2 / 72;
        t   = Q30_ONE - ((x2 * t) >> 30) / 42;
        t   = Q30_ONE - ((x2 * t) >> 30) / 20;
        t   = Q30_ONE - ((x2 * t) >> 30) / 6;
        s   = (x * t) >> 30;
        amp = (64'd1 << (SAMPLE_BITS - 1)) - 1;
        m   = (s * amp + (64'd1 << 29)) >> 30;
        if (m > amp)
        begin
            m = amp;
        end
        return (quad >= 2) ? -longint'(m) : longint'(m);
    endfunction

    // Applies one accepted beat to the predicted voice and queues the sample a tick gives.
    function automatic void voice_step(input beat_t b);
        longint          osc;
        logic            neg;
        longint unsigned m;
        logic [15:0]     res;
        beats_taken++;
        case (b.op)
            OP_NOTE_ON, OP_NOTE_OFF:
            begin
                n_note_events++;
                if (b.op == OP_NOTE_ON && b.vel != 0)
                begin
                    v_note     = b.note;
                    v_vel      = b.vel;
                    v_note_on  = 1'b1;
                    v_note_inc = note_increment(b.note);
                    v_stage    = STG_ATTACK;
                end
                else if (v_note_on && b.note == v_note)
                begin
                    v_stage = STG_DECAY;
                end
            end
            OP_TICK:
            begin
                n_ticks++;
                if (v_stage == STG_ATTACK)
                begin
                    v_env = v_env + c_attack;
                    if (v_env >= ENV_FULL)
                    begin
                        v_env   = ENV_FULL;
                        v_stage = STG_HOLD;
                    end
                end
                else if (v_stage == STG_DECAY)
                begin
                    if (c_decay >= v_env)
                    begin
                        v_env     = '0;
                        v_stage   = STG_HOLD;
                        v_note_on = 1'b0;
                    end
                    else
                    begin
                        v_env = v_env - c_decay;
                    end
                end

                osc     = osc_value(v_phase);
                v_phase = v_phase + (v_note_on ? v_note_inc : {1'b0, c_free_inc});

                if (v_note_on || v_env != 0)
                begin
                    neg = osc < 0;
                    m   = neg ? longint'(-osc) : longint'(osc);
                    m   = (m * v_env + (64'd1 << 22)) >> 23;
                    m   = (m * v_vel + 63) / 127;
                    m   = (m * c_gain + (64'd1 << (SAMPLE_BITS - 2))) >> (SAMPLE_BITS - 1);
                end
                else if (b.pres)
                begin
                    neg = b.smp[15];
                    m   = neg ? (64'd65536 - b.smp) : {48'd0, b.smp};
                    m   = (m * c_gain + (64'd1 << 14)) >> 15;
                end
                else
                begin
                    neg = osc < 0;
                    m   = neg ? longint'(-osc) : longint'(osc);
                    m   = (m * c_gain + (64'd1 << (SAMPLE_BITS - 2))) >> (SAMPLE_BITS - 1);
                end

                if (neg)
                begin
                    if (m > 32768)
                    begin
                        m = 32768;
                    end
                    res = 16'h0000 - m[15:0];
                end
                else
                begin
                    if (m > 32767)
                    begin
                        m = 32767;
                    end
                    res = m[15:0];
                end
                predicted_samples.push_back(res);
            end
            default:
            begin
                n_ignored++;
            end
        endcase
    endfunction

    // Input driver. A beat stays on the port until it is taken; the next one may follow in the
    // very next cycle, and the sender idles at random between beats.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                voice_step(cur_beat);
            end
            if (!in_valid || !in_stall)
            begin
                if (beat_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_beat <= beat_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Downstream stall. Random per cycle, except for one long hold-off, counted here, that lets
    // the output register fill and pushes the stall back to the input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_used)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_OFF_CYCLES;
            hold_used <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Output monitor. Every sample beat is matched against the oldest predicted sample.
    always @(posedge clk)
    begin : sample_monitor
        logic signed [15:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_samples.size() == 0)
            begin
                n_errors++;
                $display("%0t: unexpected sample beat, expected none, actual %0d",
                         $time, out_sample);
            end
            else
            begin
                want = predicted_samples.pop_front();
                n_checked++;
                if (out_sample !== want)
                begin
                    n_errors++;
                    $display("%0t: out_sample mismatch, expected %0d, actual %0d",
                             $time, want, out_sample);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] reg_value(input reg_e r);
        case (r)
            REG_GAIN:      return {16'd0, c_gain};
            REG_FREE_STEP: return {1'b0, c_free_inc};
            REG_ATTACK:    return {8'd0, c_attack};
            default:       return {8'd0, c_decay};
        endcase
    endfunction

    // Register write: setup cycle, then access cycle; the predictor copy follows the write
    // with the value cut to the register's width.
    task automatic apb_write(input reg_e r, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * r);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (r)
            REG_GAIN:      c_gain     = data[15:0];
            REG_FREE_STEP: c_free_inc = data[30:0];
            REG_ATTACK:    c_attack   = data[23:0];
            default:       c_decay    = data[23:0];
        endcase
    endtask

    // Register read-back, compared with the predictor copy at the access edge.
    task automatic apb_check(input reg_e r);
        logic [31:0] want;
        want = reg_value(r);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_W'(4 * r);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            n_errors++;
            $display("%0t: register %0d read-back mismatch, expected %0d, actual %0d",
                     $time, r, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] g, input logic [31:0] f,
                              input logic [31:0] a, input logic [31:0] d);
        apb_write(REG_GAIN, g);
        apb_write(REG_FREE_STEP, f);
        apb_write(REG_ATTACK, a);
        apb_write(REG_DECAY, d);
        apb_check(REG_GAIN);
        apb_check(REG_FREE_STEP);
        apb_check(REG_ATTACK);
        apb_check(REG_DECAY);
        n_settings++;
    endtask

    // Waits until every queued beat is taken and every predicted sample has come out, then
    // gives a tick still in the sequencer time to finish.
    task automatic drain();
        while (beats_taken != beats_queued || predicted_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic void push_beat(input op_e o, input logic [6:0] n, input logic [6:0] v,
                                      input logic [15:0] s, input logic p);
        beat_t b;
        b.op   = o;
        b.note = n;
        b.vel  = v;
        b.smp  = s;
        b.pres = p;
        beat_queue.push_back(b);
        beats_queued++;
        if (o != OP_UNUSED)
        begin
            beats_live++;
        end
    endfunction

    function automatic logic [6:0] rnd7();
        return 7'($urandom_range(0, 127));
    endfunction

    // Mostly random samples, with the full-scale and zero values mixed in.
    function automatic logic [15:0] rnd_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void push_ticks(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
        begin
            push_beat(OP_TICK, rnd7(), rnd7(), rnd_sample(), 1'($urandom_range(0, 1)));
        end
    endfunction

    // Random phase. Most of it is whole notes: a note on, ticks through the attack, sometimes a
    // retrigger, a release by note off or by zero velocity, and ticks through the decay. The
    // rest is bare tick runs, note offs for a note not held, and fully random beats.
    function automatic void queue_random(input int unsigned target);
        int unsigned start;
        int unsigned kind;
        logic [6:0]  held;
        start = beats_live;
        held  = rnd7();
        while (beats_live - start < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                held = rnd7();
                push_beat(OP_NOTE_ON, held, 7'($urandom_range(1, 127)), rnd_sample(),
                          1'($urandom_range(0, 1)));
                push_ticks($urandom_range(0, 30));
                if ($urandom_range(0, 3) == 0)
                begin
                    held = rnd7();
                    push_beat(OP_NOTE_ON, held, 7'($urandom_range(1, 127)), rnd_sample(),
                              1'($urandom_range(0, 1)));
                    push_ticks($urandom_range(0, 20));
                end
                if ($urandom_range(0, 1) == 0)
                begin
                    push_beat(OP_NOTE_OFF, held, rnd7(), rnd_sample(), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    push_beat(OP_NOTE_ON, held, 7'd0, rnd_sample(), 1'($urandom_range(0, 1)));
                end
                push_ticks($urandom_range(0, 40));
            end
            else if (kind < 80)
            begin
                push_ticks($urandom_range(1, 20));
            end
            else if (kind < 90)
            begin
                push_beat(OP_NOTE_OFF, held + 7'd1, rnd7(), rnd_sample(), 1'($urandom_range(0, 1)));
            end
            else
            begin
                push_beat(op_e'($urandom_range(0, 3)), rnd7(), rnd7(), rnd_sample(),
                          1'($urandom_range(0, 1)));
            end
        end
    endfunction

    // Main sequence: reset, directed beats at the reset settings, then five random phases,
    // each at its own register setting. Registers change only once the voice has drained.
    initial
    begin
        voice_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // The reset values must read back before anything is written.
        apb_check(REG_GAIN);
        apb_check(REG_FREE_STEP);
        apb_check(REG_ATTACK);
        apb_check(REG_DECAY);
        n_settings++;

        // Directed: pass-through at both full-scale inputs, the free oscillator, a note off
        // with nothing held, an unused op, the lowest note at full velocity, a foreign note off,
        // a retrigger onto the highest note, release by zero velocity, a repeated release, and a
        // plain note on and off of the tuning note.
        push_beat(OP_TICK, 7'd0, 7'd0, 16'h7FFF, 1'b1);
        push_beat(OP_TICK, 7'd127, 7'd127, 16'h8000, 1'b1);
        push_beat(OP_TICK, 7'd0, 7'd0, 16'h1234, 1'b0);
        push_beat(OP_NOTE_OFF, 7'd60, 7'd100, 16'hFFFF, 1'b1);
        push_beat(OP_UNUSED, 7'd127, 7'd127, 16'hFFFF, 1'b1);
        push_beat(OP_NOTE_ON, 7'd0, 7'd127, 16'h0000, 1'b0);
        push_ticks(2);
        push_beat(OP_NOTE_OFF, 7'd5, 7'd0, 16'h0000, 1'b0);
        push_beat(OP_NOTE_ON, 7'd127, 7'd1, 16'h0000, 1'b1);
        push_ticks(2);
        push_beat(OP_NOTE_ON, 7'd127, 7'd0, 16'h0000, 1'b0);
        push_ticks(2);
        push_beat(OP_NOTE_OFF, 7'd127, 7'd127, 16'h0000, 1'b0);
        push_ticks(1);
        push_beat(OP_NOTE_ON, 7'd69, 7'd64, 16'h0000, 1'b0);
        push_ticks(2);
        push_beat(OP_NOTE_OFF, 7'd69, 7'd0, 16'h0000, 1'b1);
        push_ticks(2);
        drain();

        // Highest gain and fastest oscillator, with the envelope jumping in a single tick.
        set_config(32'd65535, 32'd1789569706, 32'd8388608, 32'd16777215);
        queue_random(PHASE_BEATS);
        drain();

        // Downstream now mostly ready and the sender mostly idle.
        send_idle_pct = 87;
        stall_pct     = 10;

        // Zero gain, slowest oscillator and the smallest envelope steps.
        set_config(32'd0, 32'd1789570, 32'd1, 32'd1);
        queue_random(PHASE_BEATS);
        drain();

        // Junk above each register's width: gain cuts to unity, attack to zero. The long
        // hold-off happens while this phase is being sent.
        set_config(32'hFFFF_8000, 32'h8000_0000 | 32'd39370534, 32'hFF00_0000,
                   32'hFF00_0000 | 32'd300000);
        queue_random(PHASE_BEATS);
        hold_arm = 1'b1;
        drain();

        // Back to back from here on.
        send_idle_pct = 0;
        stall_pct     = 0;

        set_config($urandom_range(0, 65535), $urandom_range(1789570, 1789569706),
                   $urandom_range(50000, 2000000), $urandom_range(50000, 2000000));
        queue_random(PHASE_BEATS);
        drain();

        set_config(32'd32768, 32'd39370534, 32'd300000, 32'd200000);
        queue_random(PHASE_BEATS);
        drain();

        $display("Covered %0d ticks, %0d note events and %0d unused-op beats over %0d settings.",
                 n_ticks, n_note_events, n_ignored, n_settings);
        $display("Compared %0d output samples; %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== mono_synth_voice_envelope_unit.f =====
rtl/core/mve_pkg.sv
rtl/core/mve_regs.sv
rtl/core/mve_mac.sv
rtl/core/mono_synth_voice_envelope_unit.sv
dv/mono_synth_voice_envelope_unit_tb.sv
